// ===== design/lrt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrt_pkg: shared types and constants for the line reader with timeout
// Command codes, event codes, reader modes and the command queue entry.
// ----------------------------------------------------------------------------
package lrt_pkg;

	localparam int BUFFER_DEPTH = 256;
	localparam int EOL_LANES    = 4;
	localparam int MAX_EOL      = 4;
	localparam int TIMER_W      = 16;
	localparam int CFG_DATA_W   = 32;
	localparam int CFG_INDEX_W  = 2;

	localparam logic [CFG_INDEX_W-1:0] REG_EOL_CHARS     = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_EOL_COUNT     = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_TICKS = 2'd2;

	localparam logic [2:0] FUNC_START = 3'd0;
	localparam logic [2:0] FUNC_STOP  = 3'd1;
	localparam logic [2:0] FUNC_BYTE  = 3'd2;
	localparam logic [2:0] FUNC_TICK  = 3'd3;
	localparam logic [2:0] FUNC_READ  = 3'd4;
	localparam logic [2:0] FUNC_CLEAR = 3'd5;

	localparam logic [1:0] EV_NONE    = 2'd0;
	localparam logic [1:0] EV_OK      = 2'd1;
	localparam logic [1:0] EV_TIMEOUT = 2'd2;
	localparam logic [1:0] EV_FULL    = 2'd3;

	localparam logic [7:0] TERMINATOR = 8'h00;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_WAIT = 2'd1,
		MODE_RECV = 2'd2
	} mode_t;

	// classified command as it travels from front to back
	typedef struct packed {
		logic [2:0] func;
		logic [7:0] data;
		logic       eol;
	} cmd_t;

endpackage

// ===== design/lrt_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrt_front: command intake and end-of-line classification
// Holds the end-of-line registers and tags each accepted byte with its match.
// ----------------------------------------------------------------------------
module lrt_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [lrt_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [lrt_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [2:0]                         func,
	input  logic [7:0]                         data,
	input  logic                               q_full,
	output logic                               q_push,
	output lrt_pkg::cmd_t                      q_entry
);

	logic [8*lrt_pkg::EOL_LANES-1:0] eol_chars_q;
	logic [2:0]                      eol_count_q;
	logic [2:0]                      lanes_used;
	logic                            hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eol_chars_q <= '0;
			eol_count_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == lrt_pkg::REG_EOL_CHARS)
				eol_chars_q <= cfg_data[8*lrt_pkg::EOL_LANES-1:0];
			if (cfg_index == lrt_pkg::REG_EOL_COUNT)
				eol_count_q <= cfg_data[2:0];
		end
	end

	// saturate the lane count to the lanes that exist
	always_comb begin
		lanes_used = eol_count_q;
		if (lanes_used > 3'(lrt_pkg::EOL_LANES))
			lanes_used = 3'(lrt_pkg::EOL_LANES);
		if (lanes_used > 3'(lrt_pkg::MAX_EOL))
			lanes_used = 3'(lrt_pkg::MAX_EOL);
	end

	always_comb begin
		hit = 1'b0;
		for (int i = 0; i < lrt_pkg::EOL_LANES; i++) begin
			if ((3'(i) < lanes_used) && (eol_chars_q[8*i +: 8] == data))
				hit = 1'b1;
		end
	end

	assign in_ready      = !q_full;
	assign q_push        = in_valid && !q_full;
	assign q_entry.func  = func;
	assign q_entry.data  = data;
	assign q_entry.eol   = hit;

endmodule

// ===== design/lrt_cmd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrt_cmd_queue: two-entry command queue
// Decouples intake from execution; push and pop may happen in one cycle.
// ----------------------------------------------------------------------------
module lrt_cmd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  lrt_pkg::cmd_t push_entry,
	input  logic          pop,
	output logic          full,
	output logic          not_empty,
	output lrt_pkg::cmd_t head_entry
);

	lrt_pkg::cmd_t slot_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;

	assign full       = (count_q == 2'd2);
	assign not_empty  = (count_q != 2'd0);
	assign head_entry = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== design/lrt_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrt_back: command execution, line store and result register
// Runs the reader state machine, the tick timer and the byte FIFO.
// ----------------------------------------------------------------------------
module lrt_back #(
	parameter int BUFFER_DEPTH = lrt_pkg::BUFFER_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [lrt_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [lrt_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            q_not_empty,
	input  lrt_pkg::cmd_t                   q_entry,
	output logic                            q_pop,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [1:0]                      event_res,
	output logic                            ready_res,
	output logic [7:0]                      read_data,
	output logic                            read_valid
);

	localparam int AW = $clog2(BUFFER_DEPTH);
	localparam int FW = $clog2(BUFFER_DEPTH + 1);
	localparam int TW = lrt_pkg::TIMER_W;
	localparam logic [AW-1:0] LAST_ADDR = AW'(BUFFER_DEPTH - 1);

	logic [lrt_pkg::TIMER_W-1:0] timeout_ticks_q;

	lrt_pkg::mode_t              mode_q, mode_d;
	logic [lrt_pkg::TIMER_W-1:0] timer_q, timer_d, timer_dec;
	logic                        flag_q, flag_d;

	logic [7:0]    line_store [BUFFER_DEPTH];
	logic [AW-1:0] head_q, tail_q;
	logic [FW-1:0] fill_q;

	logic       exec;
	logic       push_req, pop_req, clear_req;
	logic [7:0] push_byte;
	logic [1:0] ev_d;
	logic       do_push, do_pop;
	logic       one_free;

	logic       out_valid_q;
	logic [1:0] event_q;
	logic       ready_q;
	logic       rvalid_q;
	logic [7:0] rdata_q;

	assign exec     = q_not_empty && (!out_valid_q || out_ready);
	assign q_pop    = exec;
	assign one_free = (fill_q == FW'(BUFFER_DEPTH - 1));
	assign timer_dec = timer_q - TW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			timeout_ticks_q <= '0;
		else if (cfg_we && cfg_index == lrt_pkg::REG_TIMEOUT_TICKS)
			timeout_ticks_q <= cfg_data[lrt_pkg::TIMER_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= lrt_pkg::MODE_IDLE;
			timer_q <= '0;
			flag_q  <= 1'b0;
		end else if (exec) begin
			mode_q  <= mode_d;
			timer_q <= timer_d;
			flag_q  <= flag_d;
		end
	end

	always_comb begin
		mode_d    = mode_q;
		timer_d   = timer_q;
		flag_d    = flag_q;
		push_req  = 1'b0;
		push_byte = q_entry.data;
		pop_req   = 1'b0;
		clear_req = 1'b0;
		ev_d      = lrt_pkg::EV_NONE;
		case (q_entry.func)
			lrt_pkg::FUNC_START: begin
				flag_d  = 1'b0;
				timer_d = '0;
				mode_d  = lrt_pkg::MODE_WAIT;
			end
			lrt_pkg::FUNC_STOP: begin
				flag_d  = 1'b1;
				timer_d = '0;
				mode_d  = lrt_pkg::MODE_IDLE;
			end
			lrt_pkg::FUNC_BYTE: begin
				case (mode_q)
					lrt_pkg::MODE_WAIT: begin
						if (!q_entry.eol) begin
							push_req = 1'b1;
							timer_d  = timeout_ticks_q;
							mode_d   = lrt_pkg::MODE_RECV;
						end
					end
					lrt_pkg::MODE_RECV: begin
						if (one_free) begin
							// last slot takes the terminator, the byte is dropped
							push_req  = 1'b1;
							push_byte = lrt_pkg::TERMINATOR;
							flag_d    = 1'b1;
							timer_d   = '0;
							mode_d    = lrt_pkg::MODE_IDLE;
							ev_d      = lrt_pkg::EV_FULL;
						end else if (q_entry.eol) begin
							push_req  = 1'b1;
							push_byte = lrt_pkg::TERMINATOR;
							flag_d    = 1'b0;
							timer_d   = '0;
							mode_d    = lrt_pkg::MODE_WAIT;
							ev_d      = lrt_pkg::EV_OK;
						end else begin
							push_req = 1'b1;
							timer_d  = timeout_ticks_q;
						end
					end
					default: ;
				endcase
			end
			lrt_pkg::FUNC_TICK: begin
				if (timer_q != '0) begin
					timer_d = timer_dec;
					if (timer_dec == '0 && mode_q != lrt_pkg::MODE_IDLE) begin
						push_req  = 1'b1;
						push_byte = lrt_pkg::TERMINATOR;
						flag_d    = 1'b1;
						mode_d    = lrt_pkg::MODE_IDLE;
						ev_d      = lrt_pkg::EV_TIMEOUT;
					end
				end
			end
			lrt_pkg::FUNC_READ:  pop_req   = 1'b1;
			lrt_pkg::FUNC_CLEAR: clear_req = 1'b1;
			default: ;
		endcase
	end

	assign do_push = exec && push_req && (fill_q != FW'(BUFFER_DEPTH));
	assign do_pop  = exec && pop_req && (fill_q != '0);

	always_ff @(posedge clk) begin
		if (do_push)
			line_store[head_q] <= push_byte;
		if (do_pop)
			rdata_q <= line_store[tail_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
		end else if (exec && clear_req) begin
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
		end else begin
			if (do_push)
				head_q <= (head_q == LAST_ADDR) ? '0 : head_q + AW'(1);
			if (do_pop)
				tail_q <= (tail_q == LAST_ADDR) ? '0 : tail_q + AW'(1);
			if (do_push)
				fill_q <= fill_q + FW'(1);
			else if (do_pop)
				fill_q <= fill_q - FW'(1);
		end
	end

	// result register; hold while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			event_q     <= lrt_pkg::EV_NONE;
			ready_q     <= 1'b0;
			rvalid_q    <= 1'b0;
		end else if (exec) begin
			out_valid_q <= 1'b1;
			event_q     <= ev_d;
			ready_q     <= flag_d;
			rvalid_q    <= do_pop;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign event_res  = event_q;
	assign ready_res  = ready_q;
	assign read_valid = rvalid_q;
	assign read_data  = rvalid_q ? rdata_q : 8'h00;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(BUFFER_DEPTH))
		else $error("line store fill count beyond depth");

	a_timer_recv: assert property (@(posedge clk) disable iff (!arst_n)
		(timer_q != '0) |-> (mode_q == lrt_pkg::MODE_RECV))
		else $error("timer running outside receive mode");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		do_pop |=> (fill_q == $past(fill_q) - FW'(1)) && rvalid_q)
		else $error("read did not remove one byte");

	a_exec_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !exec)
		else $error("command executed over a stalled result");

endmodule

// ===== design/line_reader_with_timeout.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_reader_with_timeout: frames received bytes into zero-terminated lines
//
// Commands enter on in_valid/in_ready with func and data; each command
// produces exactly one result on out_valid/out_ready (event_res, ready_res,
// read_data, read_valid). Registers are written through cfg_we, cfg_index
// and cfg_data; the user must write them only while no command is in
// flight, as the block itself does not enforce this. A transferred command
// is held in the command queue, then its result in the result register.
// Throughput: one command per cycle while the receiver takes results; the
// line store has one write and one read port, and a command touches at
// most one of them. Reset clears the reader mode, tick timer, ready flag,
// store pointers and registers; the line store itself is not cleared, since
// only written entries are ever read. There is no clearing pass.
// When the receiver stalls, the result register holds, the two-entry
// command queue fills and in_ready drops after at most two more transfers.
// ----------------------------------------------------------------------------
module line_reader_with_timeout #(
	parameter int BUFFER_DEPTH = lrt_pkg::BUFFER_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [lrt_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [lrt_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [2:0]                      func,
	input  logic [7:0]                      data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [1:0]                      event_res,
	output logic                            ready_res,
	output logic [7:0]                      read_data,
	output logic                            read_valid
);

	logic          q_full;
	logic          q_push;
	logic          q_pop;
	logic          q_not_empty;
	lrt_pkg::cmd_t push_entry;
	lrt_pkg::cmd_t head_entry;

	lrt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.data      (data),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_entry   (push_entry)
	);

	lrt_cmd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (push_entry),
		.pop        (q_pop),
		.full       (q_full),
		.not_empty  (q_not_empty),
		.head_entry (head_entry)
	);

	lrt_back #(
		.BUFFER_DEPTH (BUFFER_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.q_not_empty (q_not_empty),
		.q_entry     (head_entry),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.event_res   (event_res),
		.ready_res   (ready_res),
		.read_data   (read_data),
		.read_valid  (read_valid)
	);

endmodule
